FILE: src/xdee_pkg.sv
package xdee_pkg;

  localparam int CountWidth = 24;
  localparam int TotalWidth = 24;
  // The count never exceeds the narrower of the configured and the reported width.
  localparam int LenWidth = (CountWidth < TotalWidth) ? CountWidth : TotalWidth;

  localparam logic [7:0] CharQuot = 8'h22;
  localparam logic [7:0] CharApos = 8'h27;
  localparam logic [7:0] CharLt   = 8'h3C;
  localparam logic [7:0] CharGt   = 8'h3E;
  localparam logic [7:0] CharAmp  = 8'h26;

  // Entity strings, left aligned in ten byte slots.
  localparam logic [79:0] EntQuotStr = "&amp;quot;";
  localparam logic [79:0] EntAposStr = "&amp;apos;";
  localparam logic [79:0] EntLtStr   = {"&amp;lt;", 16'h0000};
  localparam logic [79:0] EntGtStr   = {"&amp;gt;", 16'h0000};
  localparam logic [79:0] EntAmpStr  = {"&amp;amp;", 8'h00};

  typedef enum logic [2:0] {
    EntNone,
    EntQuot,
    EntApos,
    EntLt,
    EntGt,
    EntAmp
  } ent_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  run_last;
    logic                  string_done;
    logic [TotalWidth-1:0] escaped_total;
  } out_item_t;

  // One output byte from the expander, before the length is attached.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } sym_t;

  function automatic ent_e ent_classify(logic [7:0] ch);
    ent_e e;
    unique case (ch)
      CharQuot: e = EntQuot;
      CharApos: e = EntApos;
      CharLt:   e = EntLt;
      CharGt:   e = EntGt;
      CharAmp:  e = EntAmp;
      default:  e = EntNone;
    endcase
    return e;
  endfunction

  // Index of the final byte of an entity.
  function automatic logic [3:0] ent_last_idx(ent_e e);
    logic [3:0] n;
    unique case (e)
      EntQuot, EntApos: n = 4'd9;
      EntLt, EntGt:     n = 4'd7;
      EntAmp:           n = 4'd8;
      default:          n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] ent_byte(ent_e e, logic [3:0] idx);
    logic [79:0] s;
    logic [3:0]  slot;
    unique case (e)
      EntQuot: s = EntQuotStr;
      EntApos: s = EntAposStr;
      EntLt:   s = EntLtStr;
      EntGt:   s = EntGtStr;
      EntAmp:  s = EntAmpStr;
      default: s = '0;
    endcase
    slot = (idx > 4'd9) ? 4'd0 : (4'd9 - idx);
    return s[slot*8 +: 8];
  endfunction

endpackage

FILE: src/xdee_expander.sv
module xdee_expander (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  xdee_pkg::in_item_t in_item_i,
  input  logic               step_i,
  output logic               sym_valid_o,
  output xdee_pkg::sym_t     sym_o
);

  logic               valid_q;
  xdee_pkg::in_item_t item_q;
  logic [3:0]         idx_q, idx_d;
  xdee_pkg::ent_e     ent;
  logic               last;

  assign ent  = xdee_pkg::ent_classify(item_q.char_byte);
  assign last = item_q.is_end || (idx_q == xdee_pkg::ent_last_idx(ent));

  // Take the next item as the last byte of this one leaves.
  assign in_ready_o  = !valid_q || (step_i && last);
  assign sym_valid_o = valid_q;

  always_comb begin
    sym_o.run_last    = last;
    sym_o.string_done = item_q.is_end;
    if (item_q.is_end) begin
      sym_o.out_byte = 8'h00;
    end else if (ent == xdee_pkg::EntNone) begin
      sym_o.out_byte = item_q.char_byte;
    end else begin
      sym_o.out_byte = xdee_pkg::ent_byte(ent, idx_q);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (step_i) begin
      idx_d = last ? 4'd0 : idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 4'd0;
    end else begin
      idx_q <= idx_d;
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

FILE: src/xml_double_escape_encoder_top.sv
// Double XML escape encoder. Each input item carries one string byte or an end
// mark. An ordinary byte yields one output item; a double quote, apostrophe,
// '<', '>' or '&' yields its entity (&amp;quot;, &amp;apos;, &amp;lt;,
// &amp;gt;, &amp;amp;) as 10, 10, 8, 8 or 9 output items, one per cycle
// unless the output stalls, with run_last on the final byte. An end item
// yields one zero terminator with string_done set and the saturating total,
// then clears the count. Without output stalls, plain bytes flow at one item
// per cycle and the expander's byte index steps through an entity one byte
// per cycle while input waits. Items pass the expander's item register, then
// the output register, which refills in the same cycle its byte is taken.
module xml_double_escape_encoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xdee_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output xdee_pkg::out_item_t out_item_o
);

  logic                           sym_valid;
  xdee_pkg::sym_t                 sym;
  logic                           step;
  logic [xdee_pkg::LenWidth-1:0]  count_q, count_d, count_inc;
  logic                           out_valid_q;
  xdee_pkg::out_item_t            out_q, out_d;

  xdee_expander u_expander (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .step_i      (step),
    .sym_valid_o (sym_valid),
    .sym_o       (sym)
  );

  assign step = sym_valid && (!out_valid_q || out_ready_i);

  // Saturate at all ones.
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

  always_comb begin
    count_d                = count_q;
    out_d.out_byte         = sym.out_byte;
    out_d.run_last         = sym.run_last;
    out_d.string_done      = sym.string_done;
    out_d.escaped_total    = xdee_pkg::TotalWidth'(count_q);
    if (step) begin
      if (sym.string_done) begin
        count_d = '0;
      end else begin
        count_d             = count_inc;
        out_d.escaped_total = xdee_pkg::TotalWidth'(count_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= sym_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
